### sv/afb_pkg.sv
// afb_pkg: shared types, constants and the crc byte update for the frame builder
// used by afb_front, afb_queue, afb_back and addressed_frame_builder_crc16
// no dependencies
package afb_pkg;

   localparam int unsigned QueueDepth = 4;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // one accepted payload item, classified by the front
   typedef struct packed {
      logic [7:0]  payload;
      logic        last;
      logic        first;
      logic [15:0] dest;
      logic [15:0] own;
   } afb_entry_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } afb_q_status_type;

   // reflected crc-16, one byte, lsb first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### sv/addressed_frame_builder_crc16.sv
// addressed_frame_builder_crc16: top level, frames payload bytes with header and crc-16
// depends on afb_pkg, afb_front, afb_queue, afb_back
//
//  port group   dir   contents
//  req_*        in    payload_byte, dest_address in tdata; last_payload on tlast
//  rsp_*        out   out_byte in tdata; end_of_frame on tlast
//  csr_*        in    own_address write
//
// output runs at one byte per cycle unless the receiver or an empty queue stalls it;
// the back sequencer paces it: header bytes before a first item, crc after a last
// input is taken while the queue has room, also while a result waits
// reset clears the queue, the message tracking and own_address
// own_address is sampled as an item enters
module addressed_frame_builder_crc16 #(
   parameter int unsigned QueueDepth = afb_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] payload_byte, [23:8] dest_address
   input  logic        req_tlast,   // last_payload
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // end_of_frame
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data  // own_address
);
   import afb_pkg::*;

   afb_entry_type    push_entry, head_entry;
   afb_q_status_type q_status;
   logic             push, pop;

   // front: accept and classify
   afb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   // queue between the two sides
   afb_queue #(
      .Depth(QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   // back: emit header, payload and crc bytes
   afb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .head_valid (!q_status.empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### sv/afb_queue.sv
// afb_queue: small register queue between front and back
// depends on afb_pkg for the entry and status types
module afb_queue #(
   parameter int unsigned Depth = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  afb_pkg::afb_entry_type    push_entry,
   input  logic                      pop,
   output afb_pkg::afb_entry_type    head_entry,
   output afb_pkg::afb_q_status_type status
);
   import afb_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(Depth);

   afb_entry_type   mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry   = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CntFull);
   assign status.empty = (count_ff == '0);

   // queue checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntFull)
      else $error("queue count above depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("pop from empty queue");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push without pop did not grow the queue");

endmodule

### sv/afb_front.sv
// afb_front: accepts payload items, marks message starts, holds own address
// depends on afb_pkg for the entry and status types
module afb_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [23:0]               req_tdata,   // [7:0] payload_byte, [23:8] dest_address
   input  logic                      req_tlast,   // last_payload
   input  logic                      csr_wr_en,
   input  logic [15:0]               csr_wr_data, // own_address
   input  afb_pkg::afb_q_status_type q_status,
   output logic                      push,
   output afb_pkg::afb_entry_type    push_entry
);
   import afb_pkg::*;

   logic        inside_ff, inside_in;
   logic [15:0] own_address_ff;

   assign req_tready = !q_status.full;
   assign push       = req_tvalid && req_tready;

   // classify the item
   always_comb begin
      push_entry.payload = req_tdata[7:0];
      push_entry.last    = req_tlast;
      push_entry.first   = !inside_ff;
      push_entry.dest    = req_tdata[23:8];
      push_entry.own     = own_address_ff;
      inside_in          = push ? !req_tlast : inside_ff;
   end

   // message tracking and own address register
   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff      <= 1'b0;
         own_address_ff <= '0;
      end else begin
         inside_ff <= inside_in;
         if (csr_wr_en) begin
            own_address_ff <= csr_wr_data;
         end
      end
   end

endmodule

### sv/afb_back.sv
// afb_back: byte sequencer with crc and output register
// depends on afb_pkg for the entry type and crc_feed
module afb_back (
   input  logic                   clock,
   input  logic                   reset,
   input  afb_pkg::afb_entry_type head_entry,
   input  logic                   head_valid,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,  // [7:0] out_byte
   output logic                   rsp_tlast   // end_of_frame
);
   import afb_pkg::*;

   localparam logic [2:0] PH_DST_HI  = 3'd0;
   localparam logic [2:0] PH_DST_LO  = 3'd1;
   localparam logic [2:0] PH_OWN_HI  = 3'd2;
   localparam logic [2:0] PH_OWN_LO  = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_CRC_HI  = 3'd5;
   localparam logic [2:0] PH_CRC_LO  = 3'd6;

   logic [2:0]  phase_ff, phase_in;
   logic        started_ff, started_in;
   logic [15:0] crc_ff, crc_in;
   logic        valid_ff, valid_in;
   logic [7:0]  data_ff, data_in;
   logic        eof_ff, eof_in;

   logic [2:0]  cur_phase;
   logic        slot_free, emit, done;
   logic [7:0]  byte_sel;
   logic [15:0] crc_base;

   // pick the byte for the current phase and update the crc
   always_comb begin
      cur_phase = started_ff ? phase_ff : (head_entry.first ? PH_DST_HI : PH_PAYLOAD);
      slot_free = !valid_ff || rsp_tready;
      emit      = head_valid && slot_free;
      case (cur_phase)
         PH_DST_HI:  byte_sel = head_entry.dest[15:8];
         PH_DST_LO:  byte_sel = head_entry.dest[7:0];
         PH_OWN_HI:  byte_sel = head_entry.own[15:8];
         PH_OWN_LO:  byte_sel = head_entry.own[7:0];
         PH_PAYLOAD: byte_sel = head_entry.payload;
         PH_CRC_HI:  byte_sel = crc_ff[15:8];
         PH_CRC_LO:  byte_sel = crc_ff[7:0];
         default:    byte_sel = head_entry.payload;
      endcase
      crc_base = (cur_phase == PH_DST_HI) ? CRC_INIT : crc_ff;
      done     = ((cur_phase == PH_PAYLOAD) && !head_entry.last) || (cur_phase == PH_CRC_LO);
      pop      = emit && done;

      phase_in   = phase_ff;
      started_in = started_ff;
      crc_in     = crc_ff;
      data_in    = data_ff;
      eof_in     = eof_ff;
      valid_in   = rsp_tready ? 1'b0 : valid_ff;
      if (emit) begin
         phase_in   = cur_phase + 1'b1;
         started_in = !done;
         data_in    = byte_sel;
         eof_in     = (cur_phase == PH_CRC_LO);
         valid_in   = 1'b1;
         if (cur_phase <= PH_PAYLOAD) begin
            crc_in = crc_feed(crc_base, byte_sel);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_DST_HI;
         started_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         started_ff <= started_in;
         valid_ff   <= valid_in;
      end
   end

   // crc and output payload
   always_ff @(posedge clock) begin
      crc_ff  <= crc_in;
      data_ff <= data_in;
      eof_ff  <= eof_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = eof_ff;

   // sequencer checks
   a_pop_at_end: assert property (@(posedge clock) disable iff (reset)
      pop |=> !started_ff)
      else $error("sequencer still busy after pop");
   a_eof_from_crc_lo: assert property (@(posedge clock) disable iff (reset)
      (emit && cur_phase == PH_CRC_LO) |=> (rsp_tvalid && rsp_tlast))
      else $error("frame end not flagged on crc low byte");
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> (phase_ff != 3'd7))
      else $error("sequencer phase out of range");

endmodule

### dv/addressed_frame_builder_crc16_tb.sv
// self-checking testbench for addressed_frame_builder_crc16
// predicts every frame byte (header, payload, crc-16) and compares each result item in order
// depends on the addressed_frame_builder_crc16 rtl only
`timescale 1ns / 1ps

module addressed_frame_builder_crc16_tb;

   localparam logic [15:0] CrcSeed    = 16'hFFFF;
   localparam logic [15:0] CrcPoly    = 16'hA001;
   localparam int unsigned CycleLimit = 200000;
   localparam int unsigned MaxShown   = 10;

   // receiver back-pressure patterns
   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_PERIODIC,
      RDY_SPARSE
   } ready_mode_type;

   // one predicted output item
   typedef struct packed {
      logic [7:0] value;
      logic       eof;
   } frame_byte_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;   // [7:0] payload_byte, [23:8] dest_address
   logic        req_tlast   = 1'b0; // last_payload
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;          // [7:0] out_byte
   logic        rsp_tlast;          // end_of_frame
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;   // own_address

   // framer shadow state
   logic [15:0]    shadow_crc     = CrcSeed;
   logic           shadow_in_msg  = 1'b0;
   logic [15:0]    shadow_own     = '0;
   frame_byte_type pending_frame_bytes[$];

   // bookkeeping
   int unsigned    fault_count    = 0;
   int unsigned    items_sent     = 0;
   int unsigned    frames_built   = 0;
   int unsigned    bytes_checked  = 0;
   int unsigned    own_writes     = 0;
   int unsigned    cycle_count    = 0;
   int unsigned    burst_left     = 0;
   bit             gaps_enabled   = 1'b1;
   logic [7:0]     stall_cnt      = '0;
   ready_mode_type ready_mode     = RDY_ALWAYS;

   addressed_frame_builder_crc16 u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // reflected crc-16, one data bit per step
   function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] r;
      r = crc;
      for (int k = 0; k < 8; k++) begin
         r = (r[0] ^ b[k]) ? ((r >> 1) ^ CrcPoly) : (r >> 1);
      end
      return r;
   endfunction

   function automatic void log_fault(string what);
      fault_count++;
      if (fault_count <= MaxShown) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endfunction

   // append one expected item at the tail of the queue
   function automatic void expect_byte(logic [7:0] v, logic e);
      pending_frame_bytes.insert(pending_frame_bytes.size(), '{value: v, eof: e});
   endfunction

   // header and payload bytes enter the running crc
   function automatic void push_covered_byte(logic [7:0] b);
      expect_byte(b, 1'b0);
      shadow_crc = crc16_step(shadow_crc, b);
   endfunction

   // expected output items for one accepted payload item
   function automatic void frame_item(logic [7:0] pb, logic lst, logic [15:0] da);
      if (!shadow_in_msg) begin
         shadow_crc = CrcSeed;
         push_covered_byte(da[15:8]);
         push_covered_byte(da[7:0]);
         push_covered_byte(shadow_own[15:8]);
         push_covered_byte(shadow_own[7:0]);
         shadow_in_msg = 1'b1;
      end
      push_covered_byte(pb);
      if (lst) begin
         expect_byte(shadow_crc[15:8], 1'b0);
         expect_byte(shadow_crc[7:0], 1'b1);
         shadow_crc    = CrcSeed;
         shadow_in_msg = 1'b0;
         frames_built++;
      end
   endfunction

   function automatic void check_frame_byte(logic [7:0] b, logic eof);
      frame_byte_type want;
      bytes_checked++;
      if (pending_frame_bytes.size() == 0) begin
         log_fault($sformatf("unexpected item byte=%02h eof=%b", b, eof));
      end else begin
         want = pending_frame_bytes.pop_front();
         if (b !== want.value) begin
            log_fault($sformatf("out_byte exp %02h got %02h", want.value, b));
         end
         if (eof !== want.eof) begin
            log_fault($sformatf("end_of_frame exp %b got %b (byte %02h)", want.eof, eof, b));
         end
      end
   endfunction

   // monitor: predicts on input handshakes, checks on output handshakes
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            frame_item(req_tdata[7:0], req_tlast, req_tdata[23:8]);
         end
         if (rsp_tvalid && rsp_tready) begin
            check_frame_byte(rsp_tdata, rsp_tlast);
         end
         if (csr_wr_en) begin
            shadow_own = csr_wr_data;
         end
      end
   end

   // receiver stalls, pattern changes whenever the low six bits of stall_cnt are zero
   always @(posedge clock) begin
      stall_cnt <= stall_cnt + 8'd1;
      if (stall_cnt[5:0] == 6'd0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
      end
      case (ready_mode)
         RDY_ALWAYS:   rsp_tready <= 1'b1;
         RDY_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
         RDY_PERIODIC: rsp_tready <= (stall_cnt[2:0] != 3'd5) && (stall_cnt[2:0] != 3'd6);
         default:      rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d bytes still expected",
                  cycle_count, pending_frame_bytes.size());
         $display("addressed_frame_builder_crc16 regression: fail");
         $finish;
      end
   end

   // send one payload item, bursts with random gaps between them
   task automatic send_item(input logic [7:0] pb, input logic lst, input logic [15:0] da);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = (!gaps_enabled || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {da, pb};
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      items_sent++;
   endtask

   // hold the sender until every expected item has come out
   task automatic wait_frames_done();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_frame_bytes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_own_address(input logic [15:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      own_writes++;
      @(posedge clock);
   endtask

   // broadcast and all-ones destinations show up often
   function automatic logic [15:0] pick_dest();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 2) return 16'h0000;
      if (r == 2) return 16'hFFFF;
      return 16'($urandom_range(0, 65535));
   endfunction

   // mostly short frames, a few long ones
   function automatic int unsigned pick_len();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 14) return $urandom_range(1, 4);
      if (r < 19) return $urandom_range(5, 12);
      return $urandom_range(13, 32);
   endfunction

   // later bytes carry a random destination that must be ignored
   task automatic send_frame(input int unsigned len, input logic [15:0] da);
      for (int unsigned i = 0; i < len; i++) begin
         send_item(8'($urandom_range(0, 255)), i == len - 1,
                   (i == 0) ? da : 16'($urandom_range(0, 65535)));
      end
   endtask

   // own address still at its reset value of zero
   task automatic test_reset_own_address();
      send_item(8'hA5, 1'b1, 16'h1234);
      send_item(8'h3C, 1'b0, 16'h0000);
      send_item(8'hC3, 1'b1, 16'hBEEF);
      wait_frames_done();
   endtask

   // field extremes, broadcast, destination changing mid frame
   task automatic test_field_extremes();
      write_own_address(16'hFFFF);
      send_item(8'h00, 1'b0, 16'h0000);
      send_item(8'hFF, 1'b1, 16'hFFFF);
      send_item(8'hFF, 1'b0, 16'hFFFF);
      send_item(8'h00, 1'b0, 16'h0000);
      send_item(8'h80, 1'b0, 16'h5A5A);
      send_item(8'h01, 1'b1, 16'hA5A5);
      wait_frames_done();
      write_own_address(16'h0000);
      send_item(8'h7F, 1'b0, 16'h8001);
      send_item(8'hFE, 1'b1, 16'h7FFE);
      wait_frames_done();
   endtask

   // single-byte frames back to back, header and crc from one item
   task automatic test_single_byte_frames();
      write_own_address(16'h8001);
      gaps_enabled = 1'b0;
      send_item(8'h00, 1'b1, 16'h0000);
      send_item(8'hFF, 1'b1, 16'hFFFF);
      send_item(8'h7E, 1'b1, 16'h8001);
      send_item(8'h55, 1'b1, 16'h00FF);
      send_item(8'hAA, 1'b1, 16'hFF00);
      gaps_enabled = 1'b1;
      wait_frames_done();
   endtask

   // random frames under one own address
   task automatic test_random_frames(input logic [15:0] own, input int unsigned n_items);
      int unsigned start;
      write_own_address(own);
      start = items_sent;
      while (items_sent - start < n_items) begin
         gaps_enabled = ($urandom_range(0, 3) != 0);
         send_frame(pick_len(), pick_dest());
      end
      gaps_enabled = 1'b1;
      wait_frames_done();
   endtask

   // sender pauses mid run until the block has drained
   task automatic test_pause_for_results();
      write_own_address(16'($urandom_range(0, 65535)));
      for (int i = 0; i < 4; i++) begin
         send_frame(pick_len(), pick_dest());
         wait_frames_done();
      end
   endtask

   // random last flags, frames of any length and random destinations throughout
   task automatic test_random_noise(input int unsigned n_items);
      write_own_address(16'($urandom_range(0, 65535)));
      for (int unsigned i = 0; i < n_items; i++) begin
         send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 9) < 3),
                   16'($urandom_range(0, 65535)));
      end
      send_item(8'($urandom_range(0, 255)), 1'b1, pick_dest());
      wait_frames_done();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_own_address();
      test_field_extremes();
      test_single_byte_frames();
      test_random_frames(16'hFFFF, 30);
      test_random_frames(16'h0000, 30);
      test_pause_for_results();
      test_random_frames(16'h00FF, 30);
      test_random_frames(16'hFF00, 30);
      test_random_frames(16'($urandom_range(0, 65535)), 30);
      test_random_noise(40);

      // tail: let any stray output show up before the verdict
      wait_frames_done();
      repeat (20) @(posedge clock);
      if (pending_frame_bytes.size() != 0) begin
         log_fault($sformatf("%0d expected bytes never came out", pending_frame_bytes.size()));
      end

      $display("sent %0d payload items forming %0d frames under %0d own address settings",
               items_sent, frames_built, own_writes);
      $display("checked %0d output bytes with receiver stalls and sender gaps, %0d mismatches",
               bytes_checked, fault_count);
      if (fault_count == 0) begin
         $display("addressed_frame_builder_crc16 regression: pass");
      end else begin
         $display("addressed_frame_builder_crc16 regression: fail");
      end
      $finish;
   end

endmodule
